/* sv/bals_pkg.sv */
// Shared types, operation codes and status codes for the bounded array list store.
package bals_pkg;

    localparam int CAPACITY_DEF = 64;
    localparam int WORD_W       = 32;

    typedef logic signed [WORD_W-1:0] word_t;

    // Operation codes carried by the kind field
    localparam logic [3:0] KIND_SET        = 4'd0;
    localparam logic [3:0] KIND_GET        = 4'd1;
    localparam logic [3:0] KIND_PUSH_BACK  = 4'd2;
    localparam logic [3:0] KIND_POP_BACK   = 4'd3;
    localparam logic [3:0] KIND_PUSH_FRONT = 4'd4;
    localparam logic [3:0] KIND_POP_FRONT  = 4'd5;
    localparam logic [3:0] KIND_INSERT     = 4'd6;
    localparam logic [3:0] KIND_REVERSE    = 4'd7;
    localparam logic [3:0] KIND_SIZE       = 4'd8;

    // Result status codes
    localparam logic [2:0] STAT_OK    = 3'd0;
    localparam logic [2:0] STAT_INDEX = 3'd1;
    localparam logic [2:0] STAT_EMPTY = 3'd2;
    localparam logic [2:0] STAT_FULL  = 3'd3;
    localparam logic [2:0] STAT_ADJ   = 3'd4;

    // Cell commands broadcast along the row
    typedef logic [2:0] cell_op_t;
    localparam cell_op_t CELL_HOLD   = 3'd0;
    localparam cell_op_t CELL_LOAD   = 3'd1;  // cell at threshold takes data
    localparam cell_op_t CELL_UP     = 3'd2;  // above threshold take left, at threshold take data
    localparam cell_op_t CELL_DOWN   = 3'd3;  // at or above threshold take right
    localparam cell_op_t CELL_CLEAR  = 3'd4;  // all cells to zero
    localparam cell_op_t CELL_MIRROR = 3'd5;  // cell i takes cell CAPACITY-1-i

    typedef struct packed {
        cell_op_t op;
        word_t    data;
    } cell_ctl_t;

endpackage

/* sv/bals_cell.sv */
// One storage cell of the list row: holds a word and moves it to or from its neighbors.
module bals_cell #(
    parameter int CNT_W = 7,
    parameter int INDEX = 0
) (
    input  logic               clk,
    input  logic               rst_n,
    input  bals_pkg::cell_ctl_t ctl,
    input  logic [CNT_W-1:0]   thr,
    input  bals_pkg::word_t    left_value,
    input  bals_pkg::word_t    right_value,
    input  bals_pkg::word_t    mirror_value,
    output bals_pkg::word_t    value
);
    import bals_pkg::*;

    word_t value_reg;
    word_t value_next;
    logic  at_thr;
    logic  above_thr;

    assign at_thr    = (CNT_W'(INDEX) == thr);
    assign above_thr = (CNT_W'(INDEX) > thr);

    always_comb
    begin
        value_next = value_reg;
        case (ctl.op)
            CELL_HOLD:
            begin
                value_next = value_reg;
            end
            CELL_LOAD:
            begin
                if (at_thr)
                begin
                    value_next = ctl.data;
                end
            end
            CELL_UP:
            begin
                if (above_thr)
                begin
                    value_next = left_value;
                end
                else if (at_thr)
                begin
                    value_next = ctl.data;
                end
            end
            CELL_DOWN:
            begin
                if (above_thr || at_thr)
                begin
                    value_next = right_value;
                end
            end
            CELL_CLEAR:
            begin
                value_next = '0;
            end
            CELL_MIRROR:
            begin
                value_next = mirror_value;
            end
            default:
            begin
                value_next = value_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            value_reg <= '0;
        end
        else
        begin
            value_reg <= value_next;
        end
    end

    assign value = value_reg;

endmodule

/* sv/bounded_array_list_store.sv */
// Top level of the bounded array list store: command decode, cell row and result registers.
//
// Usage:
//  - Command channel: an item (kind, position, second_position, data_value) is taken
//    at a rising edge where start is high and busy is low.
//  - Result: read_value, status and count appear for exactly one cycle with done high.
//    The receiver cannot stall; done is never raised while busy is high.
//  - Result timing: every operation except a non-empty, non-full reverse gives its result
//    in the cycle after it is taken. Reverse mirrors the whole cell row, then shifts it
//    down one cell per cycle until the list starts at slot zero again; busy is high
//    during the shift. All other items may be issued back to back, one per cycle.
//  - Configuration: cfg_valid/cfg_ready write initial_count (cfg_data). A write clears
//    the row and sets count to the written value, capped at CAPACITY. cfg_ready is low
//    while busy or while start is high.
//  - Reset: the row is cleared to zeros and count goes to zero.
//  - Slots at or above count always hold zero; the row logic relies on that.
module bounded_array_list_store #(
    parameter int CAPACITY = bals_pkg::CAPACITY_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    // command channel
    input  logic            start,
    output logic            busy,
    input  logic [3:0]      kind,
    input  logic [5:0]      position,
    input  logic [5:0]      second_position,
    input  bals_pkg::word_t data_value,
    // configuration channel
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic [6:0]      cfg_data,
    // result channel
    output logic            done,
    output bals_pkg::word_t read_value,
    output logic [2:0]      status,
    output logic [6:0]      count
);
    import bals_pkg::*;

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = $clog2(CAPACITY);
    localparam int PW    = (CNT_W > 6) ? CNT_W : 6;   // compare width for positions
    localparam int CW    = (CNT_W > 7) ? CNT_W : 7;   // compare width for config value

    localparam logic FSM_IDLE  = 1'b0;
    localparam logic FSM_SHIFT = 1'b1;

    logic             state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [CNT_W-1:0] shift_cnt_reg, shift_cnt_next;
    logic             done_reg, done_next;
    word_t            read_value_reg, read_value_next;
    logic [2:0]       status_reg, status_next;

    cell_ctl_t        ctl;
    logic [CNT_W-1:0] thr;
    word_t            cell_value [CAPACITY];

    logic             accept;
    logic             cfg_fire;
    logic [PW-1:0]    pos_w, pos2_w, n_w;
    logic [PW:0]      pos_inc;
    logic             is_empty, is_full;
    logic [CW-1:0]    cfg_ext;
    logic [CNT_W-1:0] cfg_cnt;

    assign busy      = (state_reg == FSM_SHIFT);
    assign accept    = start && !busy;
    assign cfg_ready = !busy && !start;
    assign cfg_fire  = cfg_valid && cfg_ready;

    assign pos_w    = PW'(position);
    assign pos2_w   = PW'(second_position);
    assign n_w      = PW'(cnt_reg);
    assign pos_inc  = (PW + 1)'(pos_w) + (PW + 1)'(1);
    assign is_empty = (cnt_reg == '0);
    assign is_full  = (cnt_reg >= CNT_W'(CAPACITY));

    // Initial count, capped at capacity
    assign cfg_ext = CW'(cfg_data);
    assign cfg_cnt = (cfg_ext > CW'(CAPACITY)) ? CNT_W'(CAPACITY) : CNT_W'(cfg_ext);

    // Command decode: row command and result for shift steps, config writes and accepted items
    always_comb
    begin
        state_next      = state_reg;
        cnt_next        = cnt_reg;
        shift_cnt_next  = shift_cnt_reg;
        done_next       = 1'b0;
        read_value_next = read_value_reg;
        status_next     = status_reg;
        ctl.op          = CELL_HOLD;
        ctl.data        = data_value;
        thr             = '0;

        if (state_reg == FSM_SHIFT)
        begin
            // reverse tail: slide the mirrored list down to slot zero
            ctl.op         = CELL_DOWN;
            shift_cnt_next = shift_cnt_reg - CNT_W'(1);
            if (shift_cnt_reg == CNT_W'(1))
            begin
                state_next = FSM_IDLE;
                done_next  = 1'b1;
            end
        end
        else if (cfg_fire)
        begin
            ctl.op   = CELL_CLEAR;
            cnt_next = cfg_cnt;
        end
        else if (accept)
        begin
            done_next       = 1'b1;
            read_value_next = '0;
            status_next     = STAT_OK;
            case (kind)
                KIND_SET:
                begin
                    if (pos_w >= n_w)
                    begin
                        status_next = STAT_INDEX;
                    end
                    else
                    begin
                        ctl.op = CELL_LOAD;
                        thr    = CNT_W'(pos_w);
                    end
                end
                KIND_GET:
                begin
                    if (pos_w >= n_w)
                    begin
                        status_next = STAT_INDEX;
                    end
                    else
                    begin
                        read_value_next = cell_value[pos_w[IDX_W-1:0]];
                    end
                end
                KIND_PUSH_BACK:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        ctl.op   = CELL_LOAD;
                        thr      = cnt_reg;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                KIND_POP_BACK:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        ctl.op   = CELL_LOAD;
                        ctl.data = '0;
                        thr      = cnt_reg - CNT_W'(1);
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                KIND_PUSH_FRONT:
                begin
                    if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        ctl.op   = CELL_UP;
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                KIND_POP_FRONT:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        ctl.op   = CELL_DOWN;
                        cnt_next = cnt_reg - CNT_W'(1);
                    end
                end
                KIND_INSERT:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else if (pos_w >= n_w || pos2_w >= n_w)
                    begin
                        status_next = STAT_INDEX;
                    end
                    else if ((PW + 1)'(pos2_w) != pos_inc)
                    begin
                        status_next = STAT_ADJ;
                    end
                    else if (is_full)
                    begin
                        status_next = STAT_FULL;
                    end
                    else
                    begin
                        ctl.op   = CELL_UP;
                        thr      = CNT_W'(pos2_w);
                        cnt_next = cnt_reg + CNT_W'(1);
                    end
                end
                KIND_REVERSE:
                begin
                    if (is_empty)
                    begin
                        status_next = STAT_EMPTY;
                    end
                    else
                    begin
                        // full-row mirror puts the list at the top, reversed
                        ctl.op = CELL_MIRROR;
                        if (!is_full)
                        begin
                            done_next      = 1'b0;
                            state_next     = FSM_SHIFT;
                            shift_cnt_next = CNT_W'(CAPACITY) - cnt_reg;
                        end
                    end
                end
                default:
                begin
                    // size query and unused kinds: report count only
                    status_next = STAT_OK;
                end
            endcase
        end
    end

    // Row of cells
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        word_t left_w;
        word_t right_w;

        if (i == 0)
        begin : g_first
            assign left_w = '0;
        end
        else
        begin : g_left
            assign left_w = cell_value[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign right_w = '0;
        end
        else
        begin : g_right
            assign right_w = cell_value[i+1];
        end

        bals_cell #(
            .CNT_W (CNT_W),
            .INDEX (i)
        ) u_cell (
            .clk          (clk),
            .rst_n        (rst_n),
            .ctl          (ctl),
            .thr          (thr),
            .left_value   (left_w),
            .right_value  (right_w),
            .mirror_value (cell_value[CAPACITY-1-i]),
            .value        (cell_value[i])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= FSM_IDLE;
            cnt_reg       <= '0;
            shift_cnt_reg <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            shift_cnt_reg <= shift_cnt_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
    end

    assign done       = done_reg;
    assign read_value = read_value_reg;
    assign status     = status_reg;
    assign count      = 7'(cnt_reg);

    // Checks
    a_no_done_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
        !(busy && done))
        else $error("result strobe raised during reverse shift");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CNT_W'(CAPACITY))
        else $error("element count above capacity");

    a_plain_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && kind != KIND_REVERSE) |=> done)
        else $error("non-reverse item gave no result in the next cycle");

    a_shift_end: assert property (@(posedge clk) disable iff (!rst_n)
        (busy && shift_cnt_reg == CNT_W'(1)) |=> (done && !busy))
        else $error("reverse shift did not finish with a result");

    a_shift_count_hold: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> $stable(cnt_reg))
        else $error("count changed during reverse");

endmodule

/* bench/testbench.sv */
// Self-checking testbench for the bounded array list store: directed table, then random traffic.
module testbench;

    import bals_pkg::*;

    localparam int LIST_CAP    = CAPACITY_DEF;
    localparam int CYCLE_LIMIT = 600000;
    localparam int PHASES      = 8;
    localparam int PHASE_ITEMS = 160;
    localparam int DIRECTED_N  = 29;
    localparam int REPORT_MAX  = 10;

    // kind codes the block decodes as no-ops
    localparam logic [3:0] KIND_FIRST_UNUSED = 4'd9;
    localparam logic [3:0] KIND_TOP_UNUSED   = 4'd15;

    // one result item as it shows up on the result ports
    typedef struct packed {
        word_t      read_value;
        logic [2:0] status;
        logic [6:0] count;
    } reply_t;

    // one row of the directed table: either an initial_count write or a command item,
    // optionally with the reply typed in by hand
    typedef struct packed {
        bit         is_cfg;
        logic [6:0] cfg_value;
        logic [3:0] kind;
        logic [5:0] pos;
        logic [5:0] pos2;
        word_t      data;
        bit         typed;
        reply_t     reply;
    } stim_row_t;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       start = 1'b0;
    logic       busy;
    logic [3:0] kind = '0;
    logic [5:0] position = '0;
    logic [5:0] second_position = '0;
    word_t      data_value = '0;
    logic       cfg_valid = 1'b0;
    logic       cfg_ready;
    logic [6:0] cfg_data = '0;
    logic       done;
    word_t      read_value;
    logic [2:0] status;
    logic [6:0] count;

    // hand-typed reply travels alongside the item so the checker can pick it up at accept
    bit     row_typed = 1'b0;
    reply_t row_reply = '0;

    // mirror of the list contents, updated as items and register writes are accepted
    word_t mirror_words [0:LIST_CAP-1];
    int    mirror_count;

    reply_t awaited_replies [$];
    int     mismatch_count = 0;
    int     cycle_count = 0;

    stim_row_t directed_rows [0:DIRECTED_N-1];

    bounded_array_list_store #(
        .CAPACITY(LIST_CAP)
    ) DUT (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .kind           (kind),
        .position       (position),
        .second_position(second_position),
        .data_value     (data_value),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_data       (cfg_data),
        .done           (done),
        .read_value     (read_value),
        .status         (status),
        .count          (count)
    );

    always #5 clk = ~clk;

    // Watchdog: anything stuck ends the run as a failure.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Register write semantics: store cleared, count takes the value capped at capacity.
    function automatic void reload_mirror(input logic [6:0] init_count);
        int i;
        for (i = 0; i < LIST_CAP; i++)
            mirror_words[i] = '0;
        mirror_count = (int'(init_count) > LIST_CAP) ? LIST_CAP : int'(init_count);
    endfunction

    // Predicts the reply of one command item and applies its effect to the mirror.
    // A failed operation leaves the list as it was.
    function automatic reply_t mirror_list_op(input logic [3:0] k, input logic [5:0] p,
                                              input logic [5:0] p2, input word_t d);
        reply_t r;
        int     n;
        int     i;
        word_t  t;
        r.read_value = '0;
        r.status     = STAT_OK;
        n            = mirror_count;
        case (k)
            KIND_SET:
                if (int'(p) >= n) r.status = STAT_INDEX;
                else mirror_words[p] = d;
            KIND_GET:
                if (int'(p) >= n) r.status = STAT_INDEX;
                else r.read_value = mirror_words[p];
            KIND_PUSH_BACK:
                if (n >= LIST_CAP) r.status = STAT_FULL;
                else
                begin
                    mirror_words[n] = d;
                    mirror_count    = n + 1;
                end
            KIND_POP_BACK:
                if (n == 0) r.status = STAT_EMPTY;
                else
                begin
                    mirror_words[n-1] = '0;
                    mirror_count      = n - 1;
                end
            KIND_PUSH_FRONT:
                if (n >= LIST_CAP) r.status = STAT_FULL;
                else
                begin
                    for (i = n; i > 0; i--)
                        mirror_words[i] = mirror_words[i-1];
                    mirror_words[0] = d;
                    mirror_count    = n + 1;
                end
            KIND_POP_FRONT:
                if (n == 0) r.status = STAT_EMPTY;
                else
                begin
                    for (i = 0; i + 1 < n; i++)
                        mirror_words[i] = mirror_words[i+1];
                    mirror_words[n-1] = '0;
                    mirror_count      = n - 1;
                end
            KIND_INSERT:
                // priority: empty, then range, then adjacency, then full
                if (n == 0) r.status = STAT_EMPTY;
                else if (int'(p) >= n || int'(p2) >= n) r.status = STAT_INDEX;
                else if (int'(p2) != int'(p) + 1) r.status = STAT_ADJ;
                else if (n >= LIST_CAP) r.status = STAT_FULL;
                else
                begin
                    for (i = n; i > int'(p2); i--)
                        mirror_words[i] = mirror_words[i-1];
                    mirror_words[p2] = d;
                    mirror_count     = n + 1;
                end
            KIND_REVERSE:
                if (n == 0) r.status = STAT_EMPTY;
                else
                    for (i = 0; i < n / 2; i++)
                    begin
                        t                   = mirror_words[i];
                        mirror_words[i]     = mirror_words[n-1-i];
                        mirror_words[n-1-i] = t;
                    end
            default:
                ;  // size query and unused kinds change nothing
        endcase
        r.count = mirror_count[6:0];
        return r;
    endfunction

    function automatic void flag_mismatch(input string what, input reply_t want,
                                          input reply_t got);
        mismatch_count++;
        if (mismatch_count <= REPORT_MAX)
            $display({"%0t: %s: expected value %0d status %0d count %0d, ",
                      "got value %0d status %0d count %0d"},
                     $realtime, what, want.read_value, want.status, want.count,
                     got.read_value, got.status, got.count);
    endfunction

    // Checker: all sampling happens at the rising edge, on pre-edge values.
    // Results are retired before new items are predicted; every item gives exactly one.
    always @(posedge clk)
    begin : reply_check
        reply_t want;
        reply_t got;
        if (!rst_n)
        begin
            reload_mirror('0);
        end
        else
        begin
            if (done === 1'b1)
            begin
                got = {read_value, status, count};
                if (awaited_replies.size() == 0)
                    flag_mismatch("result with nothing pending", '0, got);
                else
                begin
                    want = awaited_replies[0];
                    awaited_replies.delete(0);
                    if (got.read_value !== want.read_value)
                        flag_mismatch("read_value mismatch", want, got);
                    else if (got.status !== want.status)
                        flag_mismatch("status mismatch", want, got);
                    else if (got.count !== want.count)
                        flag_mismatch("count mismatch", want, got);
                end
            end
            if (cfg_valid && cfg_ready === 1'b1)
                reload_mirror(cfg_data);
            if (start && busy === 1'b0)
            begin
                // mirror always advances; a typed row overrides what gets compared
                want = mirror_list_op(kind, position, second_position, data_value);
                if (row_typed)
                    want = row_reply;
                awaited_replies.insert(awaited_replies.size(), want);
            end
        end
    end

    // Drives one item and returns at the edge it is taken. With gap 0 start stays high
    // so the next item follows back to back; drain holds off until all replies are in.
    task automatic issue_item(input logic [3:0] k, input logic [5:0] p, input logic [5:0] p2,
                              input word_t d, input bit typed, input reply_t typed_reply,
                              input int gap, input bit drain);
        kind            <= k;
        position        <= p;
        second_position <= p2;
        data_value      <= d;
        row_typed       <= typed;
        row_reply       <= typed_reply;
        start           <= 1'b1;
        do
            @(posedge clk);
        while (busy !== 1'b0);
        if (drain)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while (awaited_replies.size() != 0);
        end
        else if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Register writes only with the list idle: start low and no reply outstanding.
    task automatic write_initial_count(input logic [6:0] value);
        if (start)
            start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_replies.size() != 0);
        repeat ($urandom_range(0, 17)) @(posedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do
            @(posedge clk);
        while (cfg_ready !== 1'b1);
        cfg_valid <= 1'b0;
    endtask

    function automatic int draw_gap(input bit no_gaps);
        if (no_gaps || $urandom_range(0, 1) == 0)
            return 0;
        return $urandom_range(0, 17);
    endfunction

    // Random item biased toward well-formed traffic: positions mostly inside the list,
    // inserts mostly adjacent, grow_pct steering the fill level. Returns 0 for no-op kinds.
    task automatic issue_random_item(input int grow_pct, input bit no_gaps, output bit counted);
        int         pick;
        int         n;
        logic [3:0] k;
        logic [5:0] p;
        logic [5:0] p2;
        word_t      d;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            k = 4'($urandom_range(KIND_FIRST_UNUSED, KIND_TOP_UNUSED));
        else if (pick < 14)
            k = KIND_SET;
        else if (pick < 30)
            k = KIND_GET;
        else if (pick < 34)
            k = KIND_REVERSE;
        else if (pick < 38)
            k = KIND_SIZE;
        else if ($urandom_range(0, 99) < grow_pct)
            case ($urandom_range(0, 2))
                0:       k = KIND_PUSH_BACK;
                1:       k = KIND_PUSH_FRONT;
                default: k = KIND_INSERT;
            endcase
        else
            k = $urandom_range(0, 1) ? KIND_POP_BACK : KIND_POP_FRONT;

        // mirror may trail by one in-flight item; only the bias depends on it
        n  = mirror_count;
        p  = 6'($urandom_range(0, 63));
        p2 = 6'($urandom_range(0, 63));
        if (n > 0 && $urandom_range(0, 4) != 0)
            p = 6'($urandom_range(0, n - 1));
        if (k == KIND_INSERT && n >= 2 && $urandom_range(0, 3) != 0)
        begin
            p  = 6'($urandom_range(0, n - 2));
            p2 = p + 6'd1;
        end

        if ($urandom_range(0, 9) == 0)
            case ($urandom_range(0, 3))
                0:       d = 32'h7fff_ffff;
                1:       d = 32'h8000_0000;
                2:       d = 32'hffff_ffff;
                default: d = '0;
            endcase
        else
            d = $urandom;

        counted = (k < KIND_FIRST_UNUSED);
        issue_item(k, p, p2, d, 1'b0, '0, draw_gap(no_gaps), $urandom_range(0, 59) == 0);
    endtask

    function automatic stim_row_t cfg_row(input logic [6:0] value);
        stim_row_t r;
        r           = '0;
        r.is_cfg    = 1'b1;
        r.cfg_value = value;
        return r;
    endfunction

    // reply left to the mirror
    function automatic stim_row_t op_row(input logic [3:0] k, input logic [5:0] p,
                                         input logic [5:0] p2, input word_t d);
        stim_row_t r;
        r      = '0;
        r.kind = k;
        r.pos  = p;
        r.pos2 = p2;
        r.data = d;
        return r;
    endfunction

    // reply typed in by hand
    function automatic stim_row_t typed_row(input logic [3:0] k, input logic [5:0] p,
                                            input logic [5:0] p2, input word_t d,
                                            input word_t rd, input logic [2:0] st,
                                            input logic [6:0] cnt);
        stim_row_t r;
        r       = op_row(k, p, p2, d);
        r.typed = 1'b1;
        r.reply = {rd, st, cnt};
        return r;
    endfunction

    initial
    begin : stimulus
        int         ph;
        int         done_items;
        int         row;
        bit         counted;
        logic [6:0] phase_counts [0:PHASES-1];
        int         phase_grow [0:PHASES-1];

        // Directed part. Starts from the reset state: empty list, all slots zero.
        directed_rows = '{
            // empty list: every error path that needs no contents
            typed_row(KIND_SIZE,       6'd0,  6'd0,  32'h0,         32'h0, STAT_OK,    7'd0),
            typed_row(KIND_GET,        6'd0,  6'd0,  32'h0,         32'h0, STAT_INDEX, 7'd0),
            typed_row(KIND_SET,        6'd63, 6'd0,  32'hffff_ffff, 32'h0, STAT_INDEX, 7'd0),
            typed_row(KIND_POP_BACK,   6'd0,  6'd0,  32'h0,         32'h0, STAT_EMPTY, 7'd0),
            typed_row(KIND_POP_FRONT,  6'd0,  6'd0,  32'h0,         32'h0, STAT_EMPTY, 7'd0),
            typed_row(KIND_INSERT,     6'd0,  6'd1,  32'h5,         32'h0, STAT_EMPTY, 7'd0),
            typed_row(KIND_REVERSE,    6'd0,  6'd0,  32'h0,         32'h0, STAT_EMPTY, 7'd0),
            // fill with the data extremes: list becomes [min, max, -1]
            typed_row(KIND_PUSH_BACK,  6'd0,  6'd0,  32'h7fff_ffff, 32'h0, STAT_OK,    7'd1),
            typed_row(KIND_PUSH_FRONT, 6'd0,  6'd0,  32'h8000_0000, 32'h0, STAT_OK,    7'd2),
            typed_row(KIND_PUSH_BACK,  6'd0,  6'd0,  32'hffff_ffff, 32'h0, STAT_OK,    7'd3),
            typed_row(KIND_GET,        6'd0,  6'd0,  32'h0,  32'h8000_0000, STAT_OK,   7'd3),
            op_row(KIND_INSERT,        6'd0,  6'd1,  32'h1234_5678),
            // insert argument checks on a four-element list
            typed_row(KIND_INSERT,     6'd1,  6'd3,  32'h0,         32'h0, STAT_ADJ,   7'd4),
            typed_row(KIND_INSERT,     6'd2,  6'd4,  32'h0,         32'h0, STAT_INDEX, 7'd4),
            typed_row(KIND_INSERT,     6'd3,  6'd2,  32'h0,         32'h0, STAT_ADJ,   7'd4),
            // reverse must move element zero too
            op_row(KIND_REVERSE,       6'd0,  6'd0,  32'h0),
            op_row(KIND_GET,           6'd3,  6'd0,  32'h0),
            typed_row(KIND_SET,        6'd3,  6'd0,  32'h5a5a_5a5a, 32'h0, STAT_OK,    7'd4),
            op_row(KIND_POP_FRONT,     6'd0,  6'd0,  32'h0),
            op_row(KIND_POP_BACK,      6'd0,  6'd0,  32'h0),
            // top unused kind with all-ones fields is a no-op
            typed_row(KIND_TOP_UNUSED, 6'd63, 6'd63, 32'hffff_ffff, 32'h0, STAT_OK,    7'd2),
            // full list of zeros
            cfg_row(7'd64),
            typed_row(KIND_PUSH_BACK,  6'd0,  6'd0,  32'h1,         32'h0, STAT_FULL,  7'd64),
            typed_row(KIND_PUSH_FRONT, 6'd0,  6'd0,  32'h1,         32'h0, STAT_FULL,  7'd64),
            typed_row(KIND_INSERT,     6'd62, 6'd63, 32'h1,         32'h0, STAT_FULL,  7'd64),
            typed_row(KIND_INSERT,     6'd63, 6'd0,  32'h1,         32'h0, STAT_ADJ,   7'd64),
            typed_row(KIND_GET,        6'd63, 6'd0,  32'h0,         32'h0, STAT_OK,    7'd64),
            typed_row(KIND_REVERSE,    6'd0,  6'd0,  32'h0,         32'h0, STAT_OK,    7'd64),
            typed_row(KIND_POP_BACK,   6'd0,  6'd0,  32'h0,         32'h0, STAT_OK,    7'd63)
        };

        // Random phases: each starts from a fresh initial_count, extremes included
        // (127 saturates to capacity). Fill bias alternates so the list swings between
        // empty and full; every third phase runs without sender gaps.
        phase_counts = '{7'd0, 7'd127, 7'd1, 7'd64, 7'd0, 7'd63, 7'd0, 7'd2};
        phase_grow   = '{70, 35, 55, 25, 50, 60, 45, 50};

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (row = 0; row < DIRECTED_N; row++)
        begin
            if (directed_rows[row].is_cfg)
                write_initial_count(directed_rows[row].cfg_value);
            else
                issue_item(directed_rows[row].kind, directed_rows[row].pos,
                           directed_rows[row].pos2, directed_rows[row].data,
                           directed_rows[row].typed, directed_rows[row].reply,
                           draw_gap(1'b0), 1'b0);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 4 || ph == 6)
                write_initial_count(7'($urandom_range(0, 127)));
            else
                write_initial_count(phase_counts[ph]);
            done_items = 0;
            while (done_items < PHASE_ITEMS)
            begin
                issue_random_item(phase_grow[ph], (ph % 3) == 2, counted);
                if (counted)
                    done_items++;
            end
        end

        // Drain, then allow a full reverse shift worth of cycles for stray results.
        if (start)
            start <= 1'b0;
        do
            @(posedge clk);
        while (awaited_replies.size() != 0);
        repeat (LIST_CAP + 8) @(posedge clk);
        mismatch_count += awaited_replies.size();

        if (mismatch_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

/* files.f */
sv/bals_pkg.sv
sv/bals_cell.sv
sv/bounded_array_list_store.sv
bench/testbench.sv
